// File: rtl/slfr_pkg.sv
// Package for the segment LCD frame renderer.
// Holds beat types, image geometry, the glyph table, segment/sign position maps
// and the frame render function. No dependencies.
package slfr_pkg;

    // Frame geometry
    localparam int DIGITS_PER_SET = 5;
    localparam int SIGN_COUNT     = 32;
    localparam int IMAGE_BYTES    = 19;
    localparam int SEGS           = 7;
    localparam int GLYPH_COUNT    = 40;
    localparam int CODE_W         = 6;
    localparam int SET_W          = 30;
    localparam int FLAG_W         = 32;
    localparam int IDX_W          = $clog2(IMAGE_BYTES);
    localparam int IMAGE_BITS     = IMAGE_BYTES * 8;
    localparam int POS_W          = $clog2(IMAGE_BITS);

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(IMAGE_BYTES - 1);

    // Input beat: one display frame
    typedef struct packed {
        logic [SET_W-1:0]  first_set_codes;
        logic [SET_W-1:0]  second_set_codes;
        logic [FLAG_W-1:0] sign_flags;
    } frame_beat_t;

    // Output beat: one LCD data register byte
    typedef struct packed {
        logic [IDX_W-1:0] register_index;
        logic [7:0]       register_byte;
        logic             last_byte;
    } image_beat_t;

    // Whole segment image, byte 0 in the low bits
    typedef logic [IMAGE_BYTES-1:0][7:0] image_t;

    // Bit position of (register, bit) in the flattened image
    function automatic logic [POS_W-1:0] seg_pos(input int reg_idx, input int bit_idx);
        return POS_W'(reg_idx * 8 + bit_idx);
    endfunction

    // Seven-segment glyphs, segment a in bit 0
    localparam logic [SEGS-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71,
        7'h00, 7'h73, 7'h3F, 7'h76, 7'h38, 7'h06, 7'h3E, 7'h54,
        7'h7C, 7'h5E, 7'h50, 7'h5C, 7'h04, 7'h74, 7'h40, 7'h08,
        7'h00, 7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h40
    };

    // Segment positions per set, digit and segment
    localparam logic [POS_W-1:0] SET_MAP [2][5][SEGS] = '{
        '{
            '{seg_pos(1,2),  seg_pos(6,1),  seg_pos(16,1), seg_pos(16,2),
              seg_pos(11,2), seg_pos(6,2),  seg_pos(11,1)},
            '{seg_pos(1,0),  seg_pos(0,7),  seg_pos(10,7), seg_pos(16,0),
              seg_pos(11,0), seg_pos(6,0),  seg_pos(5,7)},
            '{seg_pos(0,6),  seg_pos(0,5),  seg_pos(10,5), seg_pos(15,6),
              seg_pos(10,6), seg_pos(5,6),  seg_pos(5,5)},
            '{seg_pos(0,4),  seg_pos(5,3),  seg_pos(15,3), seg_pos(15,4),
              seg_pos(10,4), seg_pos(5,4),  seg_pos(10,3)},
            '{seg_pos(0,2),  seg_pos(5,1),  seg_pos(15,1), seg_pos(15,2),
              seg_pos(10,2), seg_pos(5,2),  seg_pos(10,1)}
        },
        '{
            '{seg_pos(16,5), seg_pos(16,6), seg_pos(6,6),  seg_pos(1,5),
              seg_pos(6,5),  seg_pos(11,5), seg_pos(11,6)},
            '{seg_pos(16,7), seg_pos(17,0), seg_pos(7,0),  seg_pos(1,7),
              seg_pos(6,7),  seg_pos(11,7), seg_pos(12,0)},
            '{seg_pos(17,1), seg_pos(17,2), seg_pos(7,2),  seg_pos(2,1),
              seg_pos(7,1),  seg_pos(12,1), seg_pos(12,2)},
            '{seg_pos(17,3), seg_pos(17,4), seg_pos(7,4),  seg_pos(2,3),
              seg_pos(7,3),  seg_pos(12,3), seg_pos(12,4)},
            '{seg_pos(17,5), seg_pos(17,6), seg_pos(7,6),  seg_pos(2,5),
              seg_pos(7,5),  seg_pos(12,5), seg_pos(12,6)}
        }
    };

    // Annunciator positions; the three top flags share register 18 bit 0
    localparam logic [POS_W-1:0] SIGN_MAP [32] = '{
        seg_pos(15,5), seg_pos(15,7), seg_pos(15,0), seg_pos(10,0),
        seg_pos(2,4),  seg_pos(2,2),  seg_pos(2,0),  seg_pos(12,7),
        seg_pos(13,0), seg_pos(5,0),  seg_pos(0,0),  seg_pos(3,0),
        seg_pos(8,0),  seg_pos(2,7),  seg_pos(7,7),  seg_pos(2,6),
        seg_pos(0,1),  seg_pos(0,3),  seg_pos(1,1),  seg_pos(1,4),
        seg_pos(1,3),  seg_pos(6,3),  seg_pos(1,6),  seg_pos(6,4),
        seg_pos(16,3), seg_pos(16,4), seg_pos(11,3), seg_pos(11,4),
        seg_pos(17,7), seg_pos(18,0), seg_pos(18,0), seg_pos(18,0)
    };

    // Build the full image of one frame; all map positions are fixed wiring
    function automatic image_t render_frame(input frame_beat_t frame);
        logic [IMAGE_BITS-1:0] bits;
        logic [SET_W-1:0]      codes;
        logic [CODE_W-1:0]     code;
        logic [SEGS-1:0]       mask;
        bits = '0;
        for (int set_i = 0; set_i < 2; set_i++) begin
            codes = (set_i == 0) ? frame.first_set_codes : frame.second_set_codes;
            for (int d = 0; d < DIGITS_PER_SET; d++) begin
                code = codes[CODE_W*d +: CODE_W];
                // codes past the table render blank
                mask = (code < CODE_W'(GLYPH_COUNT)) ? GLYPH_TABLE[code] : '0;
                for (int s = 0; s < SEGS; s++) begin
                    if (mask[s]) begin
                        bits[SET_MAP[set_i][d][s]] = 1'b1;
                    end
                end
            end
        end
        for (int n = 0; n < SIGN_COUNT; n++) begin
            if (frame.sign_flags[n]) begin
                bits[SIGN_MAP[n]] = 1'b1;
            end
        end
        return image_t'(bits);
    endfunction

endpackage

// File: rtl/slfr_front.sv
// Front stage: accepts frame beats and renders them into a segment image.
// Depends on slfr_pkg.
module slfr_front
    import slfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  frame_beat_t frame,
    output logic        img_valid,
    input  logic        img_ready,
    output image_t      img
);

    logic   valid_reg;
    image_t image_reg;

    // Stage is free when empty or when the queue takes its image
    assign frame_ready = !valid_reg || img_ready;
    assign img_valid   = valid_reg;
    assign img         = image_reg;

    // Render stage register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (frame_valid && frame_ready) begin
            valid_reg <= 1'b1;
        end
        else if (img_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (frame_valid && frame_ready) begin
            image_reg <= render_frame(frame);
        end
    end

endmodule

// File: rtl/slfr_queue.sv
// Two-entry image queue between front and back stages.
// Depends on slfr_pkg.
module slfr_queue
    import slfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  image_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output image_t pop_data
);

    image_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/slfr_back.sv
// Back stage: serializes one segment image into nineteen register-byte beats.
// Depends on slfr_pkg.
module slfr_back
    import slfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        img_valid,
    output logic        img_ready,
    input  image_t      img,
    output logic        image_valid,
    input  logic        image_ready,
    output image_beat_t image
);

    image_t           image_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    image_beat_t      out_reg;
    logic             advance;
    logic             emit;
    logic             load;

    // Output register moves when empty or taken
    assign advance     = !out_valid_reg || image_ready;
    assign emit        = advance && busy_reg;
    assign img_ready   = !busy_reg || (emit && (idx_reg == LAST_INDEX));
    assign load        = img_valid && img_ready;
    assign image_valid = out_valid_reg;
    assign image       = out_reg;

    // Byte counter and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (emit) begin
            if (idx_reg == LAST_INDEX) begin
                busy_next = 1'b0;
            end
            else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (advance) begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // Image hold and output beat payload
    always_ff @(posedge clk) begin
        if (load) begin
            image_reg <= img;
        end
        if (emit) begin
            out_reg.register_index <= idx_reg;
            out_reg.register_byte  <= image_reg[idx_reg];
            out_reg.last_byte      <= (idx_reg == LAST_INDEX);
        end
    end

    // Counter never leaves the image
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= LAST_INDEX))
        else $error("byte counter past last image byte");

    // Last marker only on the final register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last_byte == (out_reg.register_index == LAST_INDEX)))
        else $error("last marker does not match register index");

    // Finishing an image without a new one leaves the back stage idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (idx_reg == LAST_INDEX) && !load) |=> !busy_reg)
        else $error("back stage still busy after last byte");

    // Loading a new image restarts the byte counter at register 0
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && (idx_reg == '0)))
        else $error("image load did not restart the byte counter");

endmodule

// File: rtl/segment_lcd_frame_renderer.sv
// Segment LCD frame renderer, top level.
// Instantiates slfr_front, slfr_queue and slfr_back; depends on slfr_pkg.
//
// Usage:
//   frame channel (frame_valid/frame_ready/frame): one beat carries a display
//   frame, two sets of five 6-bit character codes and 32 sign flags.
//   image channel (image_valid/image_ready/image): nineteen beats per frame,
//   register_index 0 to 18 in order, last_byte set on index 18.
//   Byte 0 of an accepted frame passes the front stage register, the queue and
//   the back stage's byte counter before it is registered onto the image channel.
//   Throughput: the back stage emits one register byte per cycle while
//   image_ready is high. The front renders a whole frame combinationally.
//   Front, queue and back stage hold up to four frames, with the last byte of
//   a fifth possibly still in the output register, before frame_ready drops.
//   Reset (rst_n low, asynchronous) empties the front stage, the queue and the
//   output register; no frame is in flight afterwards.
//   When the receiver holds image_ready low, the current byte stays on the
//   output, the serializer pauses, and the queue and front fill before
//   frame_ready falls. No beat is lost or repeated.
module segment_lcd_frame_renderer
    import slfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  frame_beat_t frame,
    output logic        image_valid,
    input  logic        image_ready,
    output image_beat_t image
);

    logic   front_valid;
    logic   front_ready;
    image_t front_img;
    logic   queue_valid;
    logic   queue_ready;
    image_t queue_img;

    slfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .img_valid   (front_valid),
        .img_ready   (front_ready),
        .img         (front_img)
    );

    slfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_img),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_img)
    );

    slfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .img_valid   (queue_valid),
        .img_ready   (queue_ready),
        .img         (queue_img),
        .image_valid (image_valid),
        .image_ready (image_ready),
        .image       (image)
    );

endmodule
